@@ hw/rtl/rgba_ob_pkg.sv @@
`default_nettype none

package rgba_ob_pkg;

  // Channel and numerator widths. A numerator is at most 255 times the output
  // alpha, so it fits in 16 bits and every quotient fits in 8 bits.
  localparam int ChW    = 8;
  localparam int NumW   = 2 * ChW;
  localparam int NumCh  = 3;
  localparam int DivBitsPerStage = 2;
  localparam int DivStages       = ChW / DivBitsPerStage;

  typedef logic [ChW-1:0]  chan_t;
  typedef logic [NumW-1:0] num_t;

  // Color lanes are indexed 2 = red, 1 = green, 0 = blue.
  typedef struct packed {
    chan_t [NumCh-1:0] src;
    chan_t [NumCh-1:0] dst;
    chan_t             src_a;
    chan_t             dst_w;
    chan_t             out_a;
  } wgt_t;

  typedef struct packed {
    num_t  [NumCh-1:0] rem;
    chan_t [NumCh-1:0] quot;
    chan_t             out_a;
  } div_data_t;

endpackage

`default_nettype wire

@@ hw/rtl/rgba_ob_weight.sv @@
`default_nettype none

module rgba_ob_weight (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic [31:0]        src_color,
  input  wire logic [31:0]        dst_color,
  input  wire logic               up_valid,
  output logic                    up_ready,
  output rgba_ob_pkg::wgt_t       dn_data,
  output logic                    dn_valid,
  input  wire logic               dn_ready
);
  import rgba_ob_pkg::*;

  logic  valid;
  wgt_t  data;
  wgt_t  data_next;
  chan_t inv_a;
  num_t  wprod;

  // Destination weight is dst_alpha * (255 - src_alpha) scaled down by 256.
  always_comb begin
    inv_a = 8'hFF - src_color[7:0];
    wprod = num_t'(dst_color[7:0]) * num_t'(inv_a);
    data_next.src   = src_color[31:8];
    data_next.dst   = dst_color[31:8];
    data_next.src_a = src_color[7:0];
    data_next.dst_w = wprod[NumW-1:ChW];
    data_next.out_a = src_color[7:0] + wprod[NumW-1:ChW];
  end

  // Stage register with its valid bit; it takes a transaction when empty or
  // when the stage below is taking the current one.
  assign up_ready = !valid || dn_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (up_ready) begin
      valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      data <= data_next;
    end
  end

  assign dn_data  = data;
  assign dn_valid = valid;

endmodule

`default_nettype wire

@@ hw/rtl/rgba_ob_numer.sv @@
`default_nettype none

module rgba_ob_numer (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire rgba_ob_pkg::wgt_t  up_data,
  input  wire logic               up_valid,
  output logic                    up_ready,
  output rgba_ob_pkg::div_data_t  dn_data,
  output logic                    dn_valid,
  input  wire logic               dn_ready
);
  import rgba_ob_pkg::*;

  logic      valid;
  div_data_t data;
  div_data_t data_next;

  // Alpha-weighted sum of source and destination for each color lane.
  always_comb begin
    for (int i = 0; i < NumCh; i++) begin
      data_next.rem[i]  = num_t'(up_data.src[i]) * num_t'(up_data.src_a)
                        + num_t'(up_data.dst[i]) * num_t'(up_data.dst_w);
      data_next.quot[i] = '0;
    end
    data_next.out_a = up_data.out_a;
  end

  assign up_ready = !valid || dn_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (up_ready) begin
      valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      data <= data_next;
    end
  end

  assign dn_data  = data;
  assign dn_valid = valid;

endmodule

`default_nettype wire

@@ hw/rtl/rgba_ob_div_step.sv @@
`default_nettype none

// One stage of the restoring divider: resolves two quotient bits per lane,
// most significant first. STEP selects which pair of bits.
module rgba_ob_div_step #(
  parameter int STEP = 0
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire rgba_ob_pkg::div_data_t  up_data,
  input  wire logic                    up_valid,
  output logic                         up_ready,
  output rgba_ob_pkg::div_data_t       dn_data,
  output logic                         dn_valid,
  input  wire logic                    dn_ready
);
  import rgba_ob_pkg::*;

  localparam int Hi = ChW - 1 - DivBitsPerStage * STEP;
  localparam int Lo = Hi - 1;

  logic      valid;
  div_data_t data;
  div_data_t data_next;
  num_t      trial_hi;
  num_t      trial_lo;
  num_t      rem_mid;

  assign trial_hi = num_t'(up_data.out_a) << Hi;
  assign trial_lo = num_t'(up_data.out_a) << Lo;

  // Two compare-and-subtract steps per lane. The quotient never exceeds 255,
  // so no trial above bit 7 is needed.
  always_comb begin
    data_next = up_data;
    rem_mid   = '0;
    for (int i = 0; i < NumCh; i++) begin
      rem_mid = up_data.rem[i];
      if (up_data.rem[i] >= trial_hi) begin
        rem_mid                 = up_data.rem[i] - trial_hi;
        data_next.quot[i][Hi]   = 1'b1;
      end
      data_next.rem[i] = rem_mid;
      if (rem_mid >= trial_lo) begin
        data_next.rem[i]        = rem_mid - trial_lo;
        data_next.quot[i][Lo]   = 1'b1;
      end
    end
  end

  assign up_ready = !valid || dn_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (up_ready) begin
      valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      data <= data_next;
    end
  end

  assign dn_data  = data;
  assign dn_valid = valid;

  // After this stage each remainder lies below the divisor scaled to the
  // lowest bit resolved so far; a zero alpha carries zero numerators.
  a_rem_red: assert property (@(posedge clk) disable iff (rst)
    valid && (data.out_a != '0) |-> data.rem[2] < (num_t'(data.out_a) << Lo))
    else $error("red remainder out of range after divide step");
  a_rem_green: assert property (@(posedge clk) disable iff (rst)
    valid && (data.out_a != '0) |-> data.rem[1] < (num_t'(data.out_a) << Lo))
    else $error("green remainder out of range after divide step");
  a_rem_blue: assert property (@(posedge clk) disable iff (rst)
    valid && (data.out_a != '0) |-> data.rem[0] < (num_t'(data.out_a) << Lo))
    else $error("blue remainder out of range after divide step");
  a_zero_alpha: assert property (@(posedge clk) disable iff (rst)
    valid && (data.out_a == '0) |->
      (data.rem[2] == '0) && (data.rem[1] == '0) && (data.rem[0] == '0))
    else $error("nonzero numerator with zero output alpha");

endmodule

`default_nettype wire

@@ hw/rtl/rgba_alpha_over_blend.sv @@
// Composites a non-premultiplied RGBA8888 source pixel over a destination
// pixel (red in bits 31:24, alpha in bits 7:0). One pixel pair is taken every
// clock cycle unless back-pressure from the output has filled the pipeline.
// Each result passes one pipeline register per stage: one stage forms the
// destination weight and output alpha, one forms the weighted channel sums,
// and four stages of a pipelined restoring divider each resolve two quotient
// bits for all three color channels. Throughput is set by that divider
// pipeline, which accepts a new division every cycle while not stalled. When
// the output alpha is zero the result is zero.
`default_nettype none

module rgba_alpha_over_blend (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic [31:0] src_color,
  input  wire logic [31:0] dst_color,
  input  wire logic        pix_valid,
  output logic             pix_ready,
  output logic [31:0]      blended_color,
  output logic             blend_valid,
  input  wire logic        blend_ready
);
  import rgba_ob_pkg::*;

  wgt_t      wgt_data;
  logic      wgt_valid;
  logic      wgt_ready;

  div_data_t stg_data  [DivStages+1];
  logic      stg_valid [DivStages+1];
  logic      stg_ready [DivStages+1];

  // Destination weight and output alpha.
  rgba_ob_weight u_weight (
    .clk       (clk),
    .rst       (rst),
    .src_color (src_color),
    .dst_color (dst_color),
    .up_valid  (pix_valid),
    .up_ready  (pix_ready),
    .dn_data   (wgt_data),
    .dn_valid  (wgt_valid),
    .dn_ready  (wgt_ready)
  );

  // Weighted channel sums.
  rgba_ob_numer u_numer (
    .clk      (clk),
    .rst      (rst),
    .up_data  (wgt_data),
    .up_valid (wgt_valid),
    .up_ready (wgt_ready),
    .dn_data  (stg_data[0]),
    .dn_valid (stg_valid[0]),
    .dn_ready (stg_ready[0])
  );

  // Divider pipeline, two quotient bits per stage.
  for (genvar s = 0; s < DivStages; s++) begin : g_div
    rgba_ob_div_step #(
      .STEP (s)
    ) u_step (
      .clk      (clk),
      .rst      (rst),
      .up_data  (stg_data[s]),
      .up_valid (stg_valid[s]),
      .up_ready (stg_ready[s]),
      .dn_data  (stg_data[s+1]),
      .dn_valid (stg_valid[s+1]),
      .dn_ready (stg_ready[s+1])
    );
  end

  // Pack the result; a zero output alpha gives an all-zero pixel.
  assign stg_ready[DivStages] = blend_ready;
  assign blend_valid          = stg_valid[DivStages];

  always_comb begin
    if (stg_data[DivStages].out_a == '0) begin
      blended_color = '0;
    end else begin
      blended_color = {stg_data[DivStages].quot[2], stg_data[DivStages].quot[1],
                       stg_data[DivStages].quot[0], stg_data[DivStages].out_a};
    end
  end

endmodule

`default_nettype wire

@@ tb/testbench.sv @@
`default_nettype none

module testbench;

  localparam int NumRandom  = 1250;
  localparam int HoldCycles = 80;
  localparam int HoldAfter  = 300;
  localparam int CalmTail   = 150;
  localparam int TailCycles = 20;
  localparam int WatchLimit = 2000;
  localparam int MaxReports = 10;

  typedef struct packed {
    logic [31:0] src;
    logic [31:0] dst;
  } pix_pair_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic [31:0] src_color = '0;
  logic [31:0] dst_color = '0;
  logic        pix_valid = 1'b0;
  logic        pix_ready;
  logic [31:0] blended_color;
  logic        blend_valid;
  logic        blend_ready = 1'b0;

  pix_pair_t   pair_q[$];
  logic [31:0] blend_exp_q[$];

  int n_total    = 0;
  int n_pix_in   = 0;
  int n_blend    = 0;
  int n_zero_a   = 0;
  int n_err      = 0;
  int cyc        = 0;
  int idle_cyc   = 0;
  int src_gap    = 0;
  int src_rate   = 0;
  int sink_gap   = 0;
  int sink_rate  = 0;
  int hold_cnt   = 0;
  bit hold_done  = 1'b0;

  rgba_alpha_over_blend u_top (
    .clk           (clk),
    .rst           (rst),
    .src_color     (src_color),
    .dst_color     (dst_color),
    .pix_valid     (pix_valid),
    .pix_ready     (pix_ready),
    .blended_color (blended_color),
    .blend_valid   (blend_valid),
    .blend_ready   (blend_ready)
  );

  // Free-running clock.
  initial begin
    forever #10 clk = ~clk;
  end

  // Composites the source pixel over the destination pixel. The destination
  // weight and output alpha are 8 bits wide; a zero output alpha gives zero.
  function automatic logic [31:0] over_blend(logic [31:0] s, logic [31:0] d);
    logic [7:0]  sa;
    logic [7:0]  dw;
    logic [7:0]  oa;
    logic [15:0] wprod;
    logic [15:0] num;
    logic [31:0] res;
    sa    = s[7:0];
    wprod = d[7:0] * (8'hFF - sa);
    dw    = wprod[15:8];
    oa    = sa + dw;
    res   = '0;
    if (oa != 8'd0) begin
      for (int ch = 1; ch < 4; ch++) begin
        num = s[ch*8 +: 8] * sa + d[ch*8 +: 8] * dw;
        res[ch*8 +: 8] = 8'(num / oa);
      end
      res[7:0] = oa;
    end
    return res;
  endfunction

  // Random pixel with its alpha and colors leaning toward the extremes.
  function automatic logic [31:0] rand_pixel();
    logic [7:0]  a;
    logic [23:0] rgb;
    case ($urandom_range(0, 7))
      0:       a = 8'h00;
      1:       a = 8'hFF;
      2:       a = 8'($urandom_range(0, 2));
      3:       a = 8'($urandom_range(253, 255));
      default: a = 8'($urandom);
    endcase
    case ($urandom_range(0, 9))
      0:       rgb = 24'h000000;
      1:       rgb = 24'hFFFFFF;
      default: rgb = 24'($urandom);
    endcase
    return {rgb, a};
  endfunction

  // Sender: offers the next pixel pair once the current transaction is taken,
  // with occasional idle bursts except near the end of the run.
  always @(posedge clk) begin
    pix_pair_t item;
    bit        calm;
    calm = (n_pix_in + CalmTail >= n_total);
    if (cyc % 128 == 0) begin
      src_rate <= $urandom_range(0, 3);
    end
    if (rst) begin
      pix_valid <= 1'b0;
    end else if (!pix_valid || pix_ready) begin
      if (src_gap > 0) begin
        src_gap   <= src_gap - 1;
        pix_valid <= 1'b0;
      end else if (pair_q.size() > 0) begin
        item      = pair_q.pop_front();
        src_color <= item.src;
        dst_color <= item.dst;
        pix_valid <= 1'b1;
        if (!calm && src_rate != 0 && $urandom_range(0, 15) < src_rate) begin
          src_gap <= $urandom_range(1, 7);
        end
      end else begin
        pix_valid <= 1'b0;
      end
    end
  end

  // Receiver: random stalls, plus one long hold-off that backs up the pipeline.
  always @(posedge clk) begin
    bit calm;
    calm = (n_pix_in + CalmTail >= n_total);
    if (cyc % 128 == 64) begin
      sink_rate <= $urandom_range(0, 3);
    end
    if (rst) begin
      blend_ready <= 1'b0;
    end else if (hold_cnt > 0) begin
      hold_cnt    <= hold_cnt - 1;
      blend_ready <= 1'b0;
    end else if (!hold_done && n_pix_in >= HoldAfter) begin
      hold_done   <= 1'b1;
      hold_cnt    <= HoldCycles - 1;
      blend_ready <= 1'b0;
    end else if (sink_gap > 0) begin
      sink_gap    <= sink_gap - 1;
      blend_ready <= 1'b0;
    end else if (!calm && sink_rate != 0 && $urandom_range(0, 15) < sink_rate) begin
      sink_gap    <= $urandom_range(0, 6);
      blend_ready <= 1'b0;
    end else begin
      blend_ready <= 1'b1;
    end
  end

  // Monitor: predicts each accepted pixel pair and checks each output
  // transaction against the oldest prediction.
  always @(posedge clk) begin
    logic [31:0] want;
    if (!rst && pix_valid && pix_ready) begin
      want = over_blend(src_color, dst_color);
      blend_exp_q.push_back(want);
      if (want[7:0] == 8'd0) begin
        n_zero_a <= n_zero_a + 1;
      end
      n_pix_in <= n_pix_in + 1;
    end
    if (!rst && blend_valid && blend_ready) begin
      n_blend <= n_blend + 1;
      if (blend_exp_q.size() == 0) begin
        if (n_err < MaxReports) begin
          $display("ERROR: unexpected result blended_color=%08h", blended_color);
        end
        n_err++;
      end else begin
        want = blend_exp_q.pop_front();
        if (blended_color !== want) begin
          if (n_err < MaxReports) begin
            $display("ERROR: result %0d blended_color expected %08h, got %08h",
                     n_blend, want, blended_color);
          end
          n_err++;
        end
      end
    end
  end

  // Watchdog: ends the run when no transaction happens for too long.
  always @(posedge clk) begin
    cyc <= cyc + 1;
    if (rst || (pix_valid && pix_ready) || (blend_valid && blend_ready)) begin
      idle_cyc <= 0;
    end else if (idle_cyc >= WatchLimit) begin
      $display("ERROR: no transaction for %0d cycles", WatchLimit);
      $display("** rgba_alpha_over_blend: FAILED **");
      $finish;
    end else begin
      idle_cyc <= idle_cyc + 1;
    end
  end

  // Stimulus, reset and end of run.
  initial begin
    // Directed pairs: alpha extremes, both zero-alpha cases, color extremes.
    pair_q.push_back('{32'h00000000, 32'h00000000});
    pair_q.push_back('{32'hFFFFFF00, 32'h00000000});
    pair_q.push_back('{32'hFFFFFF00, 32'hFFFFFF01});
    pair_q.push_back('{32'h00000000, 32'hFFFFFF02});
    pair_q.push_back('{32'h00000000, 32'hFFFFFF00});
    pair_q.push_back('{32'hFFFFFFFF, 32'hFFFFFFFF});
    pair_q.push_back('{32'hFFFFFF00, 32'hFFFFFFFF});
    pair_q.push_back('{32'h000000FF, 32'hFFFFFFFF});
    pair_q.push_back('{32'hFFFFFFFF, 32'h00000000});
    pair_q.push_back('{32'h00000001, 32'hFFFFFFFF});
    pair_q.push_back('{32'h80808080, 32'h7F7F7F7F});
    pair_q.push_back('{32'h12345601, 32'hABCDEF02});
    pair_q.push_back('{32'hFF0000FE, 32'h00FF00FF});
    pair_q.push_back('{32'h0000FF01, 32'hFF000001});
    pair_q.push_back('{32'hAAAAAA55, 32'h555555AA});
    pair_q.push_back('{32'h555555AA, 32'hAAAAAA55});
    pair_q.push_back('{32'hFEFEFE7F, 32'h01010180});
    for (int i = 0; i < NumRandom; i++) begin
      pair_q.push_back('{rand_pixel(), rand_pixel()});
    end
    n_total = pair_q.size();

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Drain: all pairs sent, all results seen, then a quiet tail.
    do begin
      @(negedge clk);
    end while (pair_q.size() != 0 || pix_valid || blend_exp_q.size() != 0);
    repeat (TailCycles) @(negedge clk);
    if (blend_exp_q.size() != 0) begin
      $display("ERROR: %0d results never arrived", blend_exp_q.size());
      n_err++;
    end

    $display("Composited %0d pixel pairs (%0d with zero output alpha), %0d results checked,",
             n_pix_in, n_zero_a, n_blend);
    $display("with random stalls on both sides and one %0d-cycle output hold-off; %0d errors.",
             HoldCycles, n_err);
    if (n_err == 0) begin
      $display("** rgba_alpha_over_blend: PASSED **");
    end else begin
      $display("** rgba_alpha_over_blend: FAILED **");
    end
    $finish;
  end

endmodule

`default_nettype wire
